/* hw/rtl/dvtu_pkg.sv */
// shared types, codes and helpers for the distance vector table update block
// no dependencies

package dvtu_pkg;

	localparam int ADDR_W = 32;
	localparam int COST_W = 5;
	localparam int OP_W = 2;
	localparam int STATUS_W = 3;
	localparam int RIDX_W = 6;
	localparam int TCNT_W = 7;

	localparam logic [COST_W-1:0] INF_RESET = 5'd16;

	localparam logic [OP_W-1:0] OP_LOCAL = 2'd0;
	localparam logic [OP_W-1:0] OP_ADV = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_UPDATED = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_APPENDED = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_UNCHANGED = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_READ_DONE = 3'd4;

	typedef struct packed {
		logic [ADDR_W-1:0] dest;
		logic [ADDR_W-1:0] next_hop;
		logic [ADDR_W-1:0] iface;
		logic [COST_W-1:0] cost;
		logic              is_local;
	} route_t;

	typedef struct packed {
		logic match;
		logic is_local;
		logic better;
	} cmp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CMP,
		S_READ_DATA,
		S_DONE
	} state_t;

	function automatic logic [COST_W-1:0] cap_cost(input logic [COST_W:0] c,
		input logic [COST_W-1:0] inf);
		cap_cost = (c < {1'b0, inf}) ? c[COST_W-1:0] : inf;
	endfunction

endpackage

/* hw/rtl/dvtu_if.sv */
// request, response and configuration channels of the table update block
// depends on dvtu_pkg

interface dvtu_req_if;
	import dvtu_pkg::*;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [ADDR_W-1:0]   dest_addr;
	logic [ADDR_W-1:0]   from_addr;
	logic [ADDR_W-1:0]   recv_iface;
	logic [COST_W-1:0]   adv_cost;
	logic                msg_start;
	logic [RIDX_W-1:0]   read_index;
	modport source (output valid, op, dest_addr, from_addr, recv_iface, adv_cost,
		msg_start, read_index, input ready);
	modport sink (input valid, op, dest_addr, from_addr, recv_iface, adv_cost,
		msg_start, read_index, output ready);
endinterface

interface dvtu_rsp_if;
	import dvtu_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [RIDX_W-1:0]   entry_index;
	logic [ADDR_W-1:0]   entry_dest;
	logic [ADDR_W-1:0]   entry_next_hop;
	logic [ADDR_W-1:0]   entry_iface;
	logic [COST_W-1:0]   entry_cost;
	logic                entry_local;
	logic [TCNT_W-1:0]   table_count;
	modport source (output valid, status, entry_index, entry_dest, entry_next_hop,
		entry_iface, entry_cost, entry_local, table_count, input ready);
	modport sink (input valid, status, entry_index, entry_dest, entry_next_hop,
		entry_iface, entry_cost, entry_local, table_count, output ready);
endinterface

interface dvtu_cfg_if;
	import dvtu_pkg::*;
	logic              valid;
	logic              ready;
	logic [COST_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* hw/rtl/dvtu_table.sv */
// route table storage: one write port, one registered read port
// depends on dvtu_pkg

module dvtu_table #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  dvtu_pkg::route_t  wr_data,
	input  logic [IDX_W-1:0]  rd_addr,
	output dvtu_pkg::route_t  rd_data
);
	import dvtu_pkg::*;

	route_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* hw/rtl/dvtu_cmp.sv */
// shared compare unit: destination match and replacement test for one entry
// depends on dvtu_pkg

module dvtu_cmp (
	input  dvtu_pkg::route_t                 entry,
	input  logic [dvtu_pkg::ADDR_W-1:0]      dest,
	input  logic [dvtu_pkg::ADDR_W-1:0]      from,
	input  logic [dvtu_pkg::COST_W:0]        new_cost,
	output dvtu_pkg::cmp_t                   res
);
	import dvtu_pkg::*;

	always_comb begin
		res.match = (entry.dest == dest);
		res.is_local = entry.is_local;
		res.better = (new_cost < {1'b0, entry.cost}) || (entry.next_hop == from);
	end

endmodule

/* hw/rtl/distance_vector_table_update.sv */
// distance vector route table update engine, top level and sequencer
// depends on dvtu_pkg, dvtu_if, dvtu_table, dvtu_cmp
//
// req carries one request: op 0 installs a local route, op 1 applies one
// advertised entry, op 2 reads an entry. rsp returns exactly one result per
// request. cfg writes infinity_cost at any handshake, and is always ready.
// The table is searched one entry at a time through the memory's single
// registered read port and one shared compare unit; each entry visited
// passes through S_SCAN and then S_CMP. Ops 0 and 1 stop on an entry they
// update or that is a local route, else run over all entries of their range
// (up to TABLE_DEPTH). A read in range passes through S_READ_DATA; a read
// out of range or an undefined op goes straight to S_DONE. req is not ready
// from the accepting edge until the result moves into the output register.
// A finished result waits in the output register while rsp is stalled; the
// next request can be accepted meanwhile but its result waits for the slot.
// Reset empties the table (count and message snapshot go to zero) and sets
// infinity_cost to 16; no clearing pass is needed.

module distance_vector_table_update #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	dvtu_req_if.sink    req,
	dvtu_rsp_if.source  rsp,
	dvtu_cfg_if.sink    cfg
);
	import dvtu_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	state_t state_q, state_d;

	logic [COST_W-1:0] inf_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  limit_q;
	logic [CNT_W-1:0]  idx_q;
	logic              found_q;
	logic [IDX_W-1:0]  first_idx_q;
	route_t            first_q;

	logic [OP_W-1:0]   op_q;
	logic [ADDR_W-1:0] dest_q;
	logic [ADDR_W-1:0] from_q;
	logic [ADDR_W-1:0] iface_q;
	logic [COST_W-1:0] cost_q;
	logic [RIDX_W-1:0] ridx_q;

	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic [RIDX_W-1:0]   res_index_q, res_index_d;
	route_t              res_entry_q, res_entry_d;

	logic              out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [RIDX_W-1:0] out_index_q;
	route_t            out_entry_q;
	logic [TCNT_W-1:0] out_count_q;

	logic              in_accept;
	logic              res_ld;
	logic              out_ld;
	logic              cnt_inc;
	logic              idx_inc;
	logic              first_ld;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  rd_addr;
	route_t            rd_data;
	route_t            new_entry;
	cmp_t              cmp;

	logic [COST_W:0]   new_cost;
	logic [CNT_W-1:0]  bound;
	logic              scan_end;
	logic              full;
	logic              rd_in_range;

	assign new_cost = {1'b0, cost_q} + (COST_W+1)'(1);
	assign bound = (op_q == OP_LOCAL) ? count_q : limit_q;
	assign scan_end = (idx_q >= bound);
	assign full = (count_q == CNT_W'(TABLE_DEPTH));
	assign rd_in_range = ((CNT_W+RIDX_W)'(req.read_index) < (CNT_W+RIDX_W)'(count_q));

	always_comb begin
		if (op_q == OP_LOCAL) begin
			new_entry = '{dest: dest_q, next_hop: iface_q, iface: iface_q,
				cost: cap_cost({1'b0, cost_q}, inf_q), is_local: 1'b1};
		end else begin
			new_entry = '{dest: dest_q, next_hop: from_q, iface: iface_q,
				cost: cap_cost(new_cost, inf_q), is_local: 1'b0};
		end
	end

	dvtu_table #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (new_entry),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dvtu_cmp u_cmp (
		.entry    (rd_data),
		.dest     (dest_q),
		.from     (from_q),
		.new_cost (new_cost),
		.res      (cmp)
	);

	assign in_accept = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		state_d = state_q;
		req.ready = 1'b0;
		res_ld = 1'b0;
		res_status_d = STAT_UNCHANGED;
		res_index_d = '0;
		res_entry_d = '0;
		out_ld = 1'b0;
		cnt_inc = 1'b0;
		idx_inc = 1'b0;
		first_ld = 1'b0;
		wr_en = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		rd_addr = idx_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				rd_addr = IDX_W'(req.read_index);
				if (req.valid) begin
					case (req.op)
						OP_LOCAL, OP_ADV: begin
							state_d = S_SCAN;
						end
						OP_READ: begin
							if (rd_in_range) begin
								state_d = S_READ_DATA;
							end else begin
								res_ld = 1'b1;
								res_status_d = STAT_READ_DONE;
								res_index_d = req.read_index;
								state_d = S_DONE;
							end
						end
						default: begin
							res_ld = 1'b1;
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					res_ld = 1'b1;
					state_d = S_DONE;
					if (op_q == OP_ADV && found_q) begin
						res_status_d = STAT_UNCHANGED;
						res_index_d = RIDX_W'(first_idx_q);
						res_entry_d = first_q;
					end else if (full) begin
						res_status_d = STAT_FULL;
					end else begin
						wr_en = 1'b1;
						wr_addr = count_q[IDX_W-1:0];
						cnt_inc = 1'b1;
						res_status_d = STAT_APPENDED;
						res_index_d = RIDX_W'(count_q);
						res_entry_d = new_entry;
					end
				end else begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (!cmp.match) begin
					idx_inc = 1'b1;
					state_d = S_SCAN;
				end else if (op_q == OP_LOCAL || (!cmp.is_local && cmp.better)) begin
					wr_en = 1'b1;
					res_ld = 1'b1;
					res_status_d = STAT_UPDATED;
					res_index_d = RIDX_W'(idx_q);
					res_entry_d = new_entry;
					state_d = S_DONE;
				end else if (cmp.is_local) begin
					res_ld = 1'b1;
					res_status_d = STAT_UNCHANGED;
					res_index_d = found_q ? RIDX_W'(first_idx_q) : RIDX_W'(idx_q);
					res_entry_d = found_q ? first_q : rd_data;
					state_d = S_DONE;
				end else begin
					first_ld = !found_q;
					idx_inc = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_READ_DATA: begin
				res_ld = 1'b1;
				res_status_d = STAT_READ_DONE;
				res_index_d = ridx_q;
				res_entry_d = rd_data;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			inf_q <= INF_RESET;
			count_q <= '0;
			limit_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				inf_q <= cfg.data;
			end
			if (in_accept && req.op == OP_ADV && req.msg_start) begin
				limit_q <= count_q;
			end
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (in_accept) begin
				idx_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (idx_inc) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (first_ld) begin
					found_q <= 1'b1;
				end
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q <= req.op;
			dest_q <= req.dest_addr;
			from_q <= req.from_addr;
			iface_q <= req.recv_iface;
			cost_q <= req.adv_cost;
			ridx_q <= req.read_index;
		end
		if (first_ld) begin
			first_idx_q <= idx_q[IDX_W-1:0];
			first_q <= rd_data;
		end
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_index_q <= res_index_d;
			res_entry_q <= res_entry_d;
		end
		if (out_ld) begin
			out_status_q <= res_status_q;
			out_index_q <= res_index_q;
			out_entry_q <= res_entry_q;
			out_count_q <= TCNT_W'(count_q);
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.entry_index = out_index_q;
	assign rsp.entry_dest = out_entry_q.dest;
	assign rsp.entry_next_hop = out_entry_q.next_hop;
	assign rsp.entry_iface = out_entry_q.iface;
	assign rsp.entry_cost = out_entry_q.cost;
	assign rsp.entry_local = out_entry_q.is_local;
	assign rsp.table_count = out_count_q;

endmodule

/* hw/rtl/dvtu_chk.sv */
// port level checks for the table update block, bound to the top level
// depends on dvtu_pkg and distance_vector_table_update

module dvtu_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [dvtu_pkg::STATUS_W-1:0]  rsp_status,
	input logic [dvtu_pkg::RIDX_W-1:0]    rsp_entry_index,
	input logic [dvtu_pkg::ADDR_W-1:0]    rsp_entry_dest,
	input logic [dvtu_pkg::COST_W-1:0]    rsp_entry_cost,
	input logic                           rsp_entry_local,
	input logic [dvtu_pkg::TCNT_W-1:0]    rsp_table_count
);
	import dvtu_pkg::*;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_entry_index) && $stable(rsp_table_count))
		else $error("stalled response changed");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready right after an accepted request");

	// full table carries no entry
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_FULL |-> rsp_entry_dest == '0
			&& rsp_entry_cost == '0 && !rsp_entry_local && rsp_entry_index == '0)
		else $error("full status with entry data");

	// append lands on the last slot
	a_append_idx: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_APPENDED
			|-> RIDX_W'(rsp_table_count - TCNT_W'(1)) == rsp_entry_index)
		else $error("appended index does not match count");

endmodule

bind distance_vector_table_update dvtu_chk u_dvtu_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_entry_index (rsp.entry_index),
	.rsp_entry_dest  (rsp.entry_dest),
	.rsp_entry_cost  (rsp.entry_cost),
	.rsp_entry_local (rsp.entry_local),
	.rsp_table_count (rsp.table_count)
);
